>>> rtl/mhpq_pkg.sv
// Shared types, widths and codes for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 9;
	localparam int LIMIT_W   = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;
	localparam logic [KEY_W-1:0]   EMPTY_KEY = 16'd9999;

	typedef enum logic {
		FUNC_INSERT  = 1'b0,
		FUNC_EXTRACT = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_UP_RD,
		ENG_UP_CMP,
		ENG_EX_ROOT,
		ENG_EX_LOAD,
		ENG_DN_L,
		ENG_DN_R,
		ENG_DN_CMP
	} eng_state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		func_t            func;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage

>>> rtl/mhpq_if.sv
// Request and response channel interfaces of the min-heap priority queue.
`timescale 1ns / 1ps

interface mhpq_req_if;
	import mhpq_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [KEY_W-1:0] in_key;
	logic [PAY_W-1:0] in_payload;

	modport source (output valid, func, in_key, in_payload, input ready);
	modport sink   (input valid, func, in_key, in_payload, output ready);
endinterface

interface mhpq_rsp_if;
	import mhpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    out_key;
	logic [PAY_W-1:0]    out_payload;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, out_key, out_payload, status, occupancy, input ready);
	modport sink   (input valid, out_key, out_payload, status, occupancy, output ready);
endinterface

>>> rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue.
//
// Usage: a request beat on req carries func (insert or extract), in_key and
// in_payload; each request yields exactly one response beat on rsp with
// out_key, out_payload, status and the occupancy after the operation.
// Both channels move a beat when valid and ready are high at a clock edge.
// The capacity limit is written through cfg_wr_en/cfg_wr_data while idle.
//
// The engine works on one entry memory with a single registered read port. An
// insert starts at the tail slot: it reads the parent and, while the new key is
// strictly smaller, moves the parent down a level; it writes the new entry at
// the root or below the first parent that stops it. An extract reads the root;
// unless that empties the queue it reads the last entry and sinks it, reading
// the left child, then the right, and moving the smaller child up while it is
// below the entry, until a slot without children or no smaller child. A drop on
// a full queue or an extract from an empty one is answered from the idle state.
// The engine takes one request at a time; req.ready is low while it works.
//
// Reset empties the queue and restores the limit to 256; memory contents are
// left as they are and are never read before written. When the receiver
// stalls, the response holds in the output register; the engine may still
// take and finish one more request, then holds its result until the slot frees.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
	parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mhpq_pkg::LIMIT_W-1:0] cfg_wr_data,
	mhpq_req_if.sink                     req,
	mhpq_rsp_if.source                   rsp
);
	import mhpq_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               eng_idle;
	logic               eng_start;
	req_t               eng_req;
	logic               eng_res_valid;
	logic               eng_res_ready;
	res_t               eng_res;

	logic               rsp_valid_q;
	res_t               rsp_q;

	// capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	assign req.ready = eng_idle;
	assign eng_start = req.valid && eng_idle;
	assign eng_req   = '{func: func_t'(req.func), key: req.in_key, payload: req.in_payload};

	mhpq_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.start     (eng_start),
		.req       (eng_req),
		.idle      (eng_idle),
		.res_valid (eng_res_valid),
		.res_ready (eng_res_ready),
		.res       (eng_res)
	);

	// output slot: free when empty or its beat moves this cycle
	assign eng_res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_res_ready) begin
			rsp_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_ready && eng_res_valid) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_key     = rsp_q.key;
	assign rsp.out_payload = rsp_q.payload;
	assign rsp.status      = rsp_q.status;
	assign rsp.occupancy   = rsp_q.occupancy;

endmodule

>>> rtl/mhpq_engine.sv
// Heap sequencer: entry memory, one read port, key comparators, sift up and down.
`timescale 1ns / 1ps

module mhpq_engine #(
	parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mhpq_pkg::LIMIT_W-1:0]  limit,
	input  logic                          start,
	input  mhpq_pkg::req_t                req,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output mhpq_pkg::res_t                res
);
	import mhpq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IX_W  = AW + 2;
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	eng_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [AW-1:0]    idx_q, idx_d;
	entry_t           item_q, item_d;
	entry_t           lchild_q, lchild_d;
	logic             rvalid_q, rvalid_d;
	logic [KEY_W-1:0] rkey_q, rkey_d;
	logic [PAY_W-1:0] rpay_q, rpay_d;
	status_t          rstat_q, rstat_d;
	logic             fin_q, fin_d;

	// memory port
	entry_t           mem [DEPTH];
	entry_t           rd_q;
	logic             we;
	logic [AW-1:0]    wa;
	entry_t           wd;
	logic [AW-1:0]    ra;

	logic             full;
	logic [AW-1:0]    par_ix;
	logic [IX_W-1:0]  l_ix, r_ix, n_ix;
	logic             left_wins, right_wins;
	logic [KEY_W-1:0] best_key;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign full = (CMP_W'(cnt_q) >= CMP_W'(limit)) || (cnt_q == CNT_W'(DEPTH));
	assign par_ix = (idx_q - AW'(1)) >> 1;
	assign l_ix = IX_W'({idx_q, 1'b1});
	assign r_ix = l_ix + IX_W'(1);
	assign n_ix = IX_W'(cnt_q);

	// child selection: strict less-than, left child wins ties
	assign left_wins  = lchild_q.key < item_q.key;
	assign best_key   = left_wins ? lchild_q.key : item_q.key;
	assign right_wins = rvalid_q && (rd_q.key < best_key);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		item_d   = item_q;
		lchild_d = lchild_q;
		rvalid_d = rvalid_q;
		rkey_d   = rkey_q;
		rpay_d   = rpay_q;
		rstat_d  = rstat_q;
		fin_d    = fin_q;
		we       = 1'b0;
		wa       = idx_q;
		wd       = item_q;
		ra       = idx_q;

		unique case (state_q)
			ENG_IDLE: begin
				ra = '0;
				if (fin_q && res_ready) begin
					fin_d = 1'b0;
				end
				if (start) begin
					item_d  = '{key: req.key, payload: req.payload};
					rkey_d  = '0;
					rpay_d  = '0;
					rstat_d = STAT_DONE;
					unique case (req.func)
						FUNC_INSERT: begin
							if (full) begin
								rstat_d = STAT_FULL;
								fin_d   = 1'b1;
							end else begin
								idx_d   = cnt_q[AW-1:0];
								cnt_d   = cnt_q + CNT_W'(1);
								state_d = ENG_UP_RD;
							end
						end
						FUNC_EXTRACT: begin
							if (cnt_q == '0) begin
								rkey_d  = EMPTY_KEY;
								rstat_d = STAT_EMPTY;
								fin_d   = 1'b1;
							end else begin
								cnt_d   = cnt_q - CNT_W'(1);
								state_d = ENG_EX_ROOT;
							end
						end
					endcase
				end
			end
			ENG_UP_RD: begin
				if (idx_q == '0) begin
					we      = 1'b1;
					state_d = ENG_IDLE;
					fin_d   = 1'b1;
				end else begin
					ra      = par_ix;
					state_d = ENG_UP_CMP;
				end
			end
			ENG_UP_CMP: begin
				we = 1'b1;
				if (item_q.key < rd_q.key) begin
					wd      = rd_q;
					idx_d   = par_ix;
					state_d = ENG_UP_RD;
				end else begin
					state_d = ENG_IDLE;
					fin_d   = 1'b1;
				end
			end
			ENG_EX_ROOT: begin
				// root arrives; fetch the last entry
				rkey_d = rd_q.key;
				rpay_d = rd_q.payload;
				ra     = cnt_q[AW-1:0];
				if (cnt_q == '0) begin
					state_d = ENG_IDLE;
					fin_d   = 1'b1;
				end else begin
					state_d = ENG_EX_LOAD;
				end
			end
			ENG_EX_LOAD: begin
				item_d  = rd_q;
				idx_d   = '0;
				state_d = ENG_DN_L;
			end
			ENG_DN_L: begin
				if (l_ix < n_ix) begin
					ra      = l_ix[AW-1:0];
					state_d = ENG_DN_R;
				end else begin
					we      = 1'b1;
					state_d = ENG_IDLE;
					fin_d   = 1'b1;
				end
			end
			ENG_DN_R: begin
				lchild_d = rd_q;
				rvalid_d = r_ix < n_ix;
				ra       = r_ix[AW-1:0];
				state_d  = ENG_DN_CMP;
			end
			ENG_DN_CMP: begin
				we = 1'b1;
				if (right_wins) begin
					wd      = rd_q;
					idx_d   = r_ix[AW-1:0];
					state_d = ENG_DN_L;
				end else if (left_wins) begin
					wd      = lchild_q;
					idx_d   = l_ix[AW-1:0];
					state_d = ENG_DN_L;
				end else begin
					state_d = ENG_IDLE;
					fin_d   = 1'b1;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ENG_IDLE;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			fin_q    <= fin_d;
			rvalid_q <= rvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		item_q   <= item_d;
		lchild_q <= lchild_d;
		rkey_q   <= rkey_d;
		rpay_q   <= rpay_d;
		rstat_q  <= rstat_d;
	end

	// a finished result holds the engine until the output slot takes it
	assign idle      = (state_q == ENG_IDLE) && !(fin_q && !res_ready);
	assign res_valid = fin_q && (state_q == ENG_IDLE);
	assign res       = '{key: rkey_q, payload: rpay_q, status: rstat_q,
	                     occupancy: OCC_W'(cnt_q)};

endmodule

>>> rtl/mhpq_chk.sv
// Port-level assertions for the min-heap priority queue, bound to the top level.
`timescale 1ns / 1ps

module mhpq_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mhpq_pkg::KEY_W-1:0]    out_key,
	input logic [mhpq_pkg::PAY_W-1:0]    out_payload,
	input logic [mhpq_pkg::STATUS_W-1:0] status,
	input logic [mhpq_pkg::OCC_W-1:0]    occupancy
);
	import mhpq_pkg::*;

	// a stalled response holds its beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_key) &&
		$stable(out_payload) && $stable(status) && $stable(occupancy))
		else $error("response changed while stalled");

	// every response carries a defined status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == STAT_DONE || status == STAT_FULL || status == STAT_EMPTY)
		else $error("undefined response status");

	a_empty_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_EMPTY |->
		out_key == EMPTY_KEY && out_payload == '0 && occupancy == '0)
		else $error("bad empty-extract response");

	a_full_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |-> out_key == '0 && out_payload == '0)
		else $error("bad dropped-insert response");

endmodule

bind min_heap_priority_queue mhpq_chk u_mhpq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_key     (rsp.out_key),
	.out_payload (rsp.out_payload),
	.status      (rsp.status),
	.occupancy   (rsp.occupancy)
);

>>> tb/testbench.sv
// Self-checking testbench for the min-heap priority queue: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
	import mhpq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RUN_LIMIT   = 1000000; // cycles; the slowest clean run stays far below
	localparam int DRAIN_WAIT  = 64;      // margin over the longest extract
	localparam int MAX_REPORTS = 40;      // keep the log short when the block is badly off

	// Kinds of rows in the directed table: a request beat or a limit write.
	typedef enum logic {
		ROW_ITEM,
		ROW_LIMIT
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [LIMIT_W-1:0] limit;
		func_t              func;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic               typed;  // want holds the response typed in by hand
		res_t               want;
	} row_t;

	typedef struct {
		logic [LIMIT_W-1:0] limit;
		int                 insert_pct;
		int                 idle_pct;
		int                 stall_pct;
		int                 items;
	} phase_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;

	mhpq_req_if req_ch ();
	mhpq_rsp_if rsp_ch ();

	min_heap_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	// Shadow heap: the predictor keeps its own copy of the stores, the count and the limit.
	logic [KEY_W-1:0]   heap_key [DEPTH];
	logic [PAY_W-1:0]   heap_pay [DEPTH];
	int                 heap_count;
	logic [LIMIT_W-1:0] cap_limit;

	// Responses still owed by the block, oldest first.
	res_t resp_due [$];

	int src_idle_pct;
	int snk_stall_pct;
	int errors;
	int cycle_count;

	// Run statistics for the closing summary.
	int n_insert;
	int n_extract;
	int n_dropped;
	int n_empty;
	int n_limit_writes;
	int peak_occupancy;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Exchange two heap slots, key and payload together.
	function automatic void swap_slots(int a, int b);
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		k           = heap_key[a];
		p           = heap_pay[a];
		heap_key[a] = heap_key[b];
		heap_pay[a] = heap_pay[b];
		heap_key[b] = k;
		heap_pay[b] = p;
	endfunction

	// Apply one request to the shadow heap and return the response it must produce.
	function automatic res_t heap_apply(func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		res_t r;
		int   eff;
		int   i;
		int   par;
		int   best;
		int   lc;
		int   rc;
		r           = '0;
		r.status    = STAT_DONE;
		eff         = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
		if (f == FUNC_INSERT) begin
			if (heap_count >= eff) begin
				r.status = STAT_FULL;
			end else begin
				// Append at the tail and climb while strictly below the parent.
				i = heap_count;
				heap_count++;
				heap_key[i] = k;
				heap_pay[i] = p;
				while (i != 0) begin
					par = (i - 1) / 2;
					if (heap_key[i] < heap_key[par]) begin
						swap_slots(i, par);
						i = par;
					end else begin
						break;
					end
				end
			end
		end else if (heap_count == 0) begin
			r.key    = EMPTY_KEY;
			r.status = STAT_EMPTY;
		end else begin
			// Take the root, move the tail up and sink it; the left child wins on ties.
			r.key       = heap_key[0];
			r.payload   = heap_pay[0];
			heap_count--;
			heap_key[0] = heap_key[heap_count];
			heap_pay[0] = heap_pay[heap_count];
			i = 0;
			forever begin
				best = i;
				lc   = 2 * i + 1;
				rc   = 2 * i + 2;
				if (lc < heap_count && heap_key[lc] < heap_key[best])
					best = lc;
				if (rc < heap_count && heap_key[rc] < heap_key[best])
					best = rc;
				if (best == i)
					break;
				swap_slots(i, best);
				i = best;
			end
		end
		r.occupancy = heap_count[OCC_W-1:0];
		return r;
	endfunction

	// Directed-table row builders.
	function automatic row_t op_insert(logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
			status_t st, logic [OCC_W-1:0] occ);
		row_t r;
		r                = '0;
		r.kind           = ROW_ITEM;
		r.func           = FUNC_INSERT;
		r.key            = k;
		r.payload        = p;
		r.typed          = 1'b1;
		r.want.status    = st;
		r.want.occupancy = occ;
		return r;
	endfunction

	function automatic row_t op_extract();
		row_t r;
		r      = '0;
		r.kind = ROW_ITEM;
		r.func = FUNC_EXTRACT;
		return r;
	endfunction

	function automatic row_t op_extract_empty();
		row_t r;
		r             = op_extract();
		r.typed       = 1'b1;
		r.want.key    = EMPTY_KEY;
		r.want.status = STAT_EMPTY;
		return r;
	endfunction

	function automatic row_t op_limit(logic [LIMIT_W-1:0] v);
		row_t r;
		r       = '0;
		r.kind  = ROW_LIMIT;
		r.limit = v;
		return r;
	endfunction

	// Compare one response field; flag X as well as a wrong value.
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Drop valid and hold off until every owed response has arrived.
	// Call at a falling edge at which valid has not been assigned yet.
	task automatic hold_until_drained();
		if (resp_due.size() != 0) begin
			req_ch.valid <= 1'b0;
			while (resp_due.size() != 0)
				@(negedge clk);
		end
	endtask

	// Write the capacity limit while the block is idle.
	task automatic write_limit(logic [LIMIT_W-1:0] v);
		hold_until_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_limit = v;
		n_limit_writes++;
	endtask

	// Send one request beat, then record the response it owes.
	// Enter and leave at a falling edge; valid is driven once per step.
	task automatic issue(func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
			logic typed, res_t want);
		res_t pred;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= f;
		req_ch.in_key     <= k;
		req_ch.in_payload <= p;
		// Read ready before the edge updates it: the beat moves at this edge if it is high.
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pred = heap_apply(f, k, p);
		resp_due.push_back(typed ? want : pred);
		case (pred.status)
			STAT_FULL:  n_dropped++;
			STAT_EMPTY: n_empty++;
			default: ;
		endcase
		if (f == FUNC_INSERT)
			n_insert++;
		else
			n_extract++;
		if (heap_count > peak_occupancy)
			peak_occupancy = heap_count;
		@(negedge clk);
	endtask

	// Receiver: stall at random, decided at each falling edge.
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Scoreboard: match every response beat against the oldest owed response.
	always @(posedge clk) begin : check_rsp
		res_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (resp_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("response beat with no request outstanding: key %0d, status %0d",
						rsp_ch.out_key, rsp_ch.status);
			end else begin
				want = resp_due.pop_front();
				check_field("out_key", 32'(want.key), 32'(rsp_ch.out_key));
				check_field("out_payload", 32'(want.payload), 32'(rsp_ch.out_payload));
				check_field("status", 32'(want.status), 32'(rsp_ch.status));
				check_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, resp_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		row_t   plan [27];
		phase_t phases [11];
		res_t   none;
		func_t  f;
		logic [KEY_W-1:0] k;

		// Drive every input to a known value from time zero.
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		req_ch.valid       = 1'b0;
		req_ch.func        = FUNC_INSERT;
		req_ch.in_key      = '0;
		req_ch.in_payload  = '0;
		rsp_ch.ready       = 1'b0;
		src_idle_pct       = 0;
		snk_stall_pct      = 0;
		errors             = 0;
		cycle_count        = 0;
		n_insert           = 0;
		n_extract          = 0;
		n_dropped          = 0;
		n_empty            = 0;
		n_limit_writes     = 0;
		peak_occupancy     = 0;
		heap_count         = 0;
		cap_limit          = LIMIT_RST;
		none               = '0;

		// Directed table. Inserts and empty reads have obvious responses and are typed in;
		// extracts are left to the predictor.
		plan = '{
			op_extract_empty(),                            // empty queue right after reset
			op_insert(16'hFFFF, 16'hFFFF, STAT_DONE, 1),   // largest key and handle
			op_insert(16'h0000, 16'h0000, STAT_DONE, 2),   // smallest key climbs to the root
			op_insert(16'h8000, 16'hA5A5, STAT_DONE, 3),
			op_insert(16'h0000, 16'h1234, STAT_DONE, 4),   // equal to the root: must not pass it
			op_extract(),
			op_extract(),
			op_limit(9'd0),                                // every insert now dropped
			op_insert(16'h0001, 16'h0001, STAT_FULL, 2),
			op_limit(9'd1),                                // limit below the occupancy
			op_insert(16'h0002, 16'h0002, STAT_FULL, 2),
			op_extract(),
			op_insert(16'h0004, 16'h0004, STAT_FULL, 1),   // still at the limit
			op_extract(),
			op_insert(16'h0003, 16'h0003, STAT_DONE, 1),
			op_insert(16'h0005, 16'h0005, STAT_FULL, 1),
			op_extract(),
			op_limit(9'd511),                              // above the depth: depth rules
			op_insert(16'd1, 16'd1, STAT_DONE, 1),
			op_insert(16'd7, 16'd2, STAT_DONE, 2),         // two equal children ...
			op_insert(16'd7, 16'd3, STAT_DONE, 3),
			op_insert(16'd8, 16'd4, STAT_DONE, 4),
			op_extract(),                                  // ... the left one must rise
			op_extract(),
			op_extract(),
			op_extract(),
			op_extract_empty()
		};

		// Random phases: limit, insert share, sender idle and receiver stall per hundred.
		// Fill to the depth first, then squeeze the limit, drain, and refill.
		phases = '{
			'{9'd256, 85,  0,  0, 300},
			'{9'd256, 70, 62,  0, 200},
			'{9'd8,   50,  0, 62, 150},
			'{9'd8,   30,  9,  9, 150},
			'{9'd0,   50,  0,  0,  60},
			'{9'd1,   50, 62,  0, 120},
			'{9'd511, 75,  0, 62, 250},
			'{9'd511, 60,  0,  0, 200},
			'{9'd200, 25,  9,  9, 150},
			'{9'd2,   50, 62,  0, 150},
			'{9'd256, 20,  0, 62, 200}
		};
		phases[9].limit = 9'($urandom_range(2, 40));

		// Hold reset, then release it away from the rising edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_LIMIT)
				write_limit(plan[r].limit);
			else
				issue(plan[r].func, plan[r].key, plan[r].payload, plan[r].typed, plan[r].want);
		end

		foreach (phases[ph]) begin
			write_limit(phases[ph].limit);
			src_idle_pct  = phases[ph].idle_pct;
			snk_stall_pct = phases[ph].stall_pct;
			for (int n = 0; n < phases[ph].items; n++) begin
				// Now and then let every owed response arrive before the next beat.
				if ($urandom_range(0, 99) == 0)
					hold_until_drained();
				f = ($urandom_range(0, 99) < phases[ph].insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
				// Mix narrow keys (many ties), the two extremes and full-range keys.
				case ($urandom_range(0, 3))
					0:       k = KEY_W'($urandom_range(0, 15));
					1:       k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: k = KEY_W'($urandom);
				endcase
				issue(f, k, PAY_W'($urandom), 1'b0, none);
			end
		end

		// Let the last responses come home, then watch for stray beats.
		src_idle_pct = 0;
		hold_until_drained();
		snk_stall_pct = 0;
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Covered %0d inserts (%0d dropped on a full queue) and %0d extracts (%0d on empty)",
			n_insert, n_dropped, n_extract, n_empty);
		$display("Peak occupancy %0d over %0d limit writes, %0d mismatches",
			peak_occupancy, n_limit_writes, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> min_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_engine.sv
rtl/min_heap_priority_queue.sv
rtl/mhpq_chk.sv
tb/testbench.sv
